[rtl/sbsh_pkg.sv]
// Shared types, constants and functions for the SHA-256 byte stream hasher.
// No dependencies; every other file in rtl/ imports this package.
package sbsh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [0:7][31:0] hash_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;

	// Control from the sequencer to the message schedule window.
	typedef struct packed {
		logic       shift;
		logic [7:0] din;
		logic       advance;
	} sched_ctl_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PADZ   = 6'b000010,
		ST_PADLEN = 6'b000100,
		ST_COMP   = 6'b001000,
		ST_FOLD   = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	localparam hash_t H_INIT = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

[rtl/sbsh_msg_sched.sv]
// Block buffer and message schedule: a 16-word window that takes bytes while
// the block fills and slides one word per round during compression. Uses sbsh_pkg.
module sbsh_msg_sched (
	input  logic                clk,
	input  sbsh_pkg::sched_ctl_t ctl,
	output sbsh_pkg::word_t     w_cur
);
	import sbsh_pkg::*;

	logic [511:0] win_q;
	word_t        w_new;

	// The top word is the schedule word of the current round.
	assign w_cur = win_q[511:480];

	assign w_new = small_sigma1(win_q[63:32]) + win_q[223:192]
		+ small_sigma0(win_q[479:448]) + win_q[511:480];

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			win_q <= {win_q[503:0], ctl.din};
		end else if (ctl.advance) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

endmodule

[rtl/sbsh_round_unit.sv]
// Shared compression round: holds the working variables a..h and applies one
// SHA-256 round per cycle while advance is high. Uses sbsh_pkg for the round constants and sigmas.
module sbsh_round_unit (
	input  logic            clk,
	input  logic            load,
	input  logic            advance,
	input  logic [5:0]      rnd,
	input  sbsh_pkg::word_t w_cur,
	input  sbsh_pkg::hash_t chain,
	output sbsh_pkg::hash_t work
);
	import sbsh_pkg::*;

	hash_t v_q;
	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[rnd] + w_cur;
	assign t2  = big_sigma0(v_q[0]) + maj;
	assign work = v_q;

	always_ff @(posedge clk) begin
		if (load) begin
			v_q <= chain;
		end else if (advance) begin
			v_q <= '{t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
		end
	end

endmodule

[rtl/sha256_byte_stream_hasher_core.sv]
// Top level of the SHA-256 byte stream hasher: sequencer, chaining state,
// length counters and output register. Uses sbsh_pkg, sbsh_msg_sched, sbsh_round_unit.
//
// Usage: the input channel carries one word per item: either a message byte
// to absorb or a finish command. The output channel returns the digest as
// eight 32-bit big-endian words, index 0 first, last_word set on index 7.
// An absorb shifts its byte into the block buffer; the 64th byte of a block also
// starts the 64 rounds of the shared round unit and the fold into the chaining state.
// A finish appends padding one byte per cycle outside compressions, with a turn
// in ST_PADZ before the length bytes, runs one compression, or two when the
// padding spills into a second block, then loads the eight digest words into
// the output register one per cycle while the receiver does not stall.
// in_stall is high whenever the sequencer is busy; it drops once the last
// digest word is in the output register, so the next message can start while
// that word still waits. A stall on the output holds the word and the
// sequencer. Reset clears the sequencer and loads the initial hash values;
// the block is then ready for a new message, as it is after every finish.
module sha256_byte_stream_hasher_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sbsh_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sbsh_pkg::out_item_t  out_data
);
	import sbsh_pkg::*;

	state_t     state_q;
	state_t     ret_q;
	logic [5:0] fill_q;
	logic [5:0] rnd_q;
	logic [2:0] len_idx_q;
	logic [2:0] oidx_q;
	logic [63:0] bits_q;
	logic [63:0] total_q;
	hash_t      chain_q;
	hash_t      work;
	word_t      w_cur;
	sched_ctl_t sched_ctl;
	logic       go_comp;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		sched_ctl = '0;
		go_comp   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					sched_ctl.shift = 1'b1;
					sched_ctl.din   = (in_data.opcode == OP_FINISH) ? PAD_MARK
						: in_data.data_byte;
					go_comp = (fill_q == 6'd63);
				end
			end
			ST_PADZ: begin
				if (fill_q != 6'd56) begin
					sched_ctl.shift = 1'b1;
					go_comp = (fill_q == 6'd63);
				end
			end
			ST_PADLEN: begin
				sched_ctl.shift = 1'b1;
				sched_ctl.din   = total_q[63:56];
				go_comp = (len_idx_q == 3'd7);
			end
			ST_COMP: begin
				sched_ctl.advance = 1'b1;
			end
			default: begin
			end
		endcase
	end

	sbsh_msg_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.w_cur (w_cur)
	);

	sbsh_round_unit u_round (
		.clk     (clk),
		.load    (go_comp),
		.advance (sched_ctl.advance),
		.rnd     (rnd_q),
		.w_cur   (w_cur),
		.chain   (chain_q),
		.work    (work)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= ST_IDLE;
			fill_q    <= '0;
			rnd_q     <= '0;
			len_idx_q <= '0;
			oidx_q    <= '0;
			bits_q    <= '0;
			total_q   <= '0;
			chain_q   <= H_INIT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						fill_q <= fill_q + 6'd1;
						if (in_data.opcode == OP_FINISH) begin
							total_q <= bits_q + {55'b0, fill_q, 3'b000};
						end
						if (go_comp) begin
							ret_q   <= (in_data.opcode == OP_FINISH) ? ST_PADZ : ST_IDLE;
							state_q <= ST_COMP;
						end else if (in_data.opcode == OP_FINISH) begin
							state_q <= ST_PADZ;
						end
					end
				end
				ST_PADZ: begin
					if (fill_q == 6'd56) begin
						len_idx_q <= '0;
						state_q   <= ST_PADLEN;
					end else begin
						fill_q <= fill_q + 6'd1;
						if (go_comp) begin
							ret_q   <= ST_PADZ;
							state_q <= ST_COMP;
						end
					end
				end
				ST_PADLEN: begin
					fill_q    <= fill_q + 6'd1;
					total_q   <= {total_q[55:0], 8'h00};
					len_idx_q <= len_idx_q + 3'd1;
					if (go_comp) begin
						ret_q   <= ST_OUT;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work[i];
					end
					if (ret_q == ST_IDLE) begin
						bits_q <= bits_q + 64'd512;
					end
					oidx_q  <= '0;
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (out_load) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							// Message done: back to the initial state.
							chain_q <= H_INIT;
							bits_q  <= '0;
							fill_q  <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.digest_word <= chain_q[oidx_q];
			out_q.word_index  <= oidx_q;
			out_q.last_word   <= (oidx_q == 3'd7);
		end
	end

`ifndef NO_ASSERTIONS
	a_out_only_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("digest word appeared outside the output phase");

	a_comp_starts_at_round0: assert property (@(posedge clk) disable iff (!arst_n)
		go_comp |=> (state_q == ST_COMP) && (rnd_q == 6'd0))
		else $error("compression did not start at round zero");

	a_fold_with_empty_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> (fill_q == 6'd0))
		else $error("block buffer count not wrapped at fold");
`endif

endmodule
